[sv/poisson_disc_candidate_filter_top_macros.svh]
// assertion macros for the candidate filter
`ifndef POISSON_DISC_CANDIDATE_FILTER_TOP_MACROS_SVH
`define POISSON_DISC_CANDIDATE_FILTER_TOP_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define PDCF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the next cycle
`define PDCF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/pdcf_pkg.sv]
package pdcf_pkg;

  localparam int MAX_GRID_COLS_DEF = 64;
  localparam int MAX_GRID_ROWS_DEF = 64;

  localparam logic [1:0] OP_TEST  = 2'd0;
  localparam logic [1:0] OP_FORCE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [2:0] CFG_AREA_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_AREA_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_CELL_EDGE   = 3'd2;
  localparam logic [2:0] CFG_RADIUS_SQ   = 3'd3;
  localparam logic [2:0] CFG_GRID_COLS   = 3'd4;
  localparam logic [2:0] CFG_GRID_ROWS   = 3'd5;

  localparam int COORD_W  = 16;
  localparam int RADIUS_W = 35;
  localparam int DIM_W    = 7;
  localparam int CFG_W    = 35;
  // occupancy tag width, a full tag pass runs on a clear once the epoch is all ones
  localparam int EPOCH_W  = 4;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_DIV,
    ST_CHECK,
    ST_SCAN_RD,
    ST_SCAN_WAIT,
    ST_SCAN_EVAL,
    ST_WRITE,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input item
    logic div_start;  // start both dividers
    logic win_init;   // set up window bounds and scan position
    logic clr_step;   // clear one occupancy tag
    logic ep_bump;    // move to the next epoch, empties the grid
    logic rd_issue;   // read memory at scan position
    logic eval;       // compare the read cell
    logic advance;    // step scan position
    logic wr;         // store the point
    logic set_acc;    // result accepted
    logic out_load;   // load the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic clr_last;
    logic ep_full;    // epoch at its last value, next clear needs a tag pass
    logic is_clear;
    logic is_force;
    logic is_test;
    logic pre_ok;     // inside the area and own cell empty
    logic scan_last;
    logic near_hit;   // last evaluated cell is too close
  } stat_t;

endpackage

[sv/pdcf_div.sv]
// restoring divider, one quotient bit per cycle, zero divisor gives all ones
module pdcf_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] quotient
);
  logic [15:0] rem;
  logic [15:0] quo;
  logic [15:0] dvs;
  logic [4:0]  cnt;
  logic        busy;
  logic [16:0] trial;

  assign trial = {rem, quo[15]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd16;
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        if (trial[16]) begin
          rem <= {rem[14:0], quo[15]};
          quo <= {quo[14:0], 1'b0};
        end else begin
          rem <= trial[15:0];
          quo <= {quo[14:0], 1'b1};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;
endmodule

[sv/pdcf_ctrl.sv]
module pdcf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_fire,
  input  logic            out_busy,
  input  pdcf_pkg::stat_t st,
  output logic            in_ready,
  output pdcf_pkg::cmd_t  cmd
);
  pdcf_pkg::state_t state, state_next;
  logic acc, acc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pdcf_pkg::ST_INIT;
      acc   <= 1'b0;
    end else begin
      state <= state_next;
      acc   <= acc_next;
    end
  end

  always_comb begin
    state_next = state;
    acc_next   = acc;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      pdcf_pkg::ST_INIT: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) state_next = pdcf_pkg::ST_IDLE;
      end
      pdcf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load   = 1'b1;
          acc_next   = 1'b0;
          state_next = pdcf_pkg::ST_DIV;
        end
      end
      pdcf_pkg::ST_DIV: begin
        if (st.is_clear) begin
          if (st.ep_full) begin
            state_next = pdcf_pkg::ST_CLEAR;
          end else begin
            cmd.ep_bump = 1'b1;
            state_next  = pdcf_pkg::ST_OUT;
          end
        end else if (!st.is_test && !st.is_force) begin
          state_next = pdcf_pkg::ST_OUT;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = pdcf_pkg::ST_CHECK;
        end
      end
      pdcf_pkg::ST_CHECK: begin
        if (st.div_done) begin
          cmd.win_init = 1'b1;
          state_next   = pdcf_pkg::ST_SCAN_RD;
        end
      end
      pdcf_pkg::ST_SCAN_RD: begin
        if (st.is_force) begin
          state_next = pdcf_pkg::ST_WRITE;
        end else if (!st.pre_ok) begin
          state_next = pdcf_pkg::ST_OUT;
        end else begin
          cmd.rd_issue = 1'b1;
          state_next   = pdcf_pkg::ST_SCAN_WAIT;
        end
      end
      pdcf_pkg::ST_SCAN_WAIT: begin
        cmd.eval   = 1'b1;
        state_next = pdcf_pkg::ST_SCAN_EVAL;
      end
      pdcf_pkg::ST_SCAN_EVAL: begin
        if (st.near_hit) begin
          state_next = pdcf_pkg::ST_OUT;
        end else if (st.scan_last) begin
          state_next = pdcf_pkg::ST_WRITE;
        end else begin
          cmd.advance = 1'b1;
          state_next  = pdcf_pkg::ST_SCAN_RD;
        end
      end
      pdcf_pkg::ST_WRITE: begin
        cmd.wr     = 1'b1;
        acc_next   = 1'b1;
        state_next = pdcf_pkg::ST_OUT;
      end
      pdcf_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) state_next = pdcf_pkg::ST_OUT;
      end
      pdcf_pkg::ST_OUT: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          cmd.set_acc  = acc;
          state_next   = pdcf_pkg::ST_IDLE;
        end
      end
      default: state_next = pdcf_pkg::ST_IDLE;
    endcase
  end
endmodule

[sv/pdcf_dp.sv]
module pdcf_dp #(
  parameter int MAX_GRID_COLS = pdcf_pkg::MAX_GRID_COLS_DEF,
  parameter int MAX_GRID_ROWS = pdcf_pkg::MAX_GRID_ROWS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  pdcf_pkg::cmd_t  cmd,
  input  logic [1:0]      in_op,
  input  logic [15:0]     in_x,
  input  logic [15:0]     in_y,
  input  logic [15:0]     area_width,
  input  logic [15:0]     area_height,
  input  logic [15:0]     cell_edge,
  input  logic [34:0]     radius_sq,
  input  logic [6:0]      grid_cols,
  input  logic [6:0]      grid_rows,
  output pdcf_pkg::stat_t st,
  output logic [5:0]      res_col,
  output logic [5:0]      res_row
);
  localparam int CW = $clog2(MAX_GRID_COLS);
  localparam int RW = $clog2(MAX_GRID_ROWS);
  localparam int AW = CW + RW;
  localparam int DEPTH = 2 ** AW;
  localparam int EW = pdcf_pkg::EPOCH_W;

  // coordinate memory, one read and one write port
  logic [31:0] pt_mem [DEPTH];
  // occupancy tags: a cell is taken when its tag equals the current epoch
  logic [EW-1:0] tag_mem [DEPTH];

  logic [1:0]  op;
  logic [15:0] px, py;
  logic [CW-1:0] col, c0, c1, cs;
  logic [RW-1:0] row, r0, r1, rs;
  logic [AW-1:0] clr_addr;
  logic [EW-1:0] epoch, own_tag, rd_tag;
  logic          tag_we;
  logic [AW-1:0] tag_waddr;
  logic [EW-1:0] tag_wdata;
  logic [8:0]  cols_c, rows_c;
  logic        dvx_done, dvy_done, dvx_seen, dvy_seen;
  logic [15:0] qx, qy;
  logic [31:0] rd_pt;
  logic        rd_occ, own_occ;
  logic        near;
  logic [16:0] dx, dy;
  logic [15:0] adx, ady;
  logic [31:0] sqx, sqy;

  pdcf_div u_divx (.clk, .rst, .start(cmd.div_start), .dividend(px), .divisor(cell_edge),
    .done(dvx_done), .quotient(qx));
  pdcf_div u_divy (.clk, .rst, .start(cmd.div_start), .dividend(py), .divisor(cell_edge),
    .done(dvy_done), .quotient(qy));

  always_comb begin
    cols_c = (grid_cols == 7'd0) ? 9'd1 :
      ({2'b0, grid_cols} > 9'(MAX_GRID_COLS)) ? 9'(MAX_GRID_COLS) : {2'b0, grid_cols};
    rows_c = (grid_rows == 7'd0) ? 9'd1 :
      ({2'b0, grid_rows} > 9'(MAX_GRID_ROWS)) ? 9'(MAX_GRID_ROWS) : {2'b0, grid_rows};
  end

  // saturate quotient to last column and row
  logic [CW-1:0] col_sat;
  logic [RW-1:0] row_sat;
  always_comb begin
    col_sat = ({1'b0, qx} > 17'(cols_c - 9'd1)) ? CW'(cols_c - 9'd1) : CW'(qx);
    row_sat = ({1'b0, qy} > 17'(rows_c - 9'd1)) ? RW'(rows_c - 9'd1) : RW'(qy);
    if (cell_edge == 16'd0) begin
      col_sat = CW'(cols_c - 9'd1);
      row_sat = RW'(rows_c - 9'd1);
    end
  end

  // one tag write a cycle: clearing pass or point store
  assign tag_we    = cmd.clr_step || cmd.wr;
  assign tag_waddr = cmd.clr_step ? clr_addr : {row, col};
  assign tag_wdata = cmd.clr_step ? '0 : epoch;

  always_ff @(posedge clk) begin
    if (rst) begin
      dvx_seen <= 1'b0;
      dvy_seen <= 1'b0;
      clr_addr <= '0;
      epoch    <= EW'(1);
    end else begin
      if (cmd.div_start) begin
        dvx_seen <= 1'b0;
        dvy_seen <= 1'b0;
      end else begin
        if (dvx_done) dvx_seen <= 1'b1;
        if (dvy_done) dvy_seen <= 1'b1;
      end
      if (cmd.clr_step) clr_addr <= clr_addr + AW'(1);
      // tags are all zero after a pass, so epoch one starts empty
      if (cmd.clr_step && clr_addr == '1) epoch <= EW'(1);
      else if (cmd.ep_bump) epoch <= epoch + EW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= in_op;
      px <= in_x;
      py <= in_y;
    end
    if (cmd.win_init) begin
      col <= col_sat;
      row <= row_sat;
      c0  <= (col_sat >= CW'(2)) ? col_sat - CW'(2) : '0;
      r0  <= (row_sat >= RW'(2)) ? row_sat - RW'(2) : '0;
      c1  <= ((10'(col_sat) + 10'd3) < 10'(cols_c)) ? col_sat + CW'(3) : CW'(cols_c - 9'd1) + CW'(1);
      r1  <= ((10'(row_sat) + 10'd3) < 10'(rows_c)) ? row_sat + RW'(3) : RW'(rows_c - 9'd1) + RW'(1);
      cs  <= (col_sat >= CW'(2)) ? col_sat - CW'(2) : '0;
      rs  <= (row_sat >= RW'(2)) ? row_sat - RW'(2) : '0;
      own_tag <= tag_mem[{row_sat, col_sat}];
    end
    if (cmd.rd_issue) begin
      rd_pt  <= pt_mem[{rs, cs}];
      rd_tag <= tag_mem[{rs, cs}];
    end
    if (tag_we) tag_mem[tag_waddr] <= tag_wdata;
    if (cmd.wr) pt_mem[{row, col}] <= {py, px};
    if (cmd.advance) begin
      if (cs + CW'(1) == c1 || (c1 == '0 && cs == '1)) begin
        cs <= c0;
        rs <= rs + RW'(1);
      end else begin
        cs <= cs + CW'(1);
      end
    end
    if (cmd.eval) begin
      sqx <= adx * adx;
      sqy <= ady * ady;
    end
  end

  assign own_occ = (own_tag == epoch);
  assign rd_occ  = (rd_tag == epoch);

  // end column may wrap to zero when it equals the full width
  logic col_end, row_end;
  assign col_end = (c1 == '0) ? (cs == '1) : (cs + CW'(1) == c1);
  assign row_end = (r1 == '0) ? (rs == '1) : (rs + RW'(1) == r1);

  assign dx  = {1'b0, rd_pt[15:0]} - {1'b0, px};
  assign dy  = {1'b0, rd_pt[31:16]} - {1'b0, py};
  assign adx = dx[16] ? 16'(-dx) : dx[15:0];
  assign ady = dy[16] ? 16'(-dy) : dy[15:0];

  logic eval_q;
  always_ff @(posedge clk) begin
    if (rst) eval_q <= 1'b0;
    else     eval_q <= cmd.eval;
  end
  assign near = eval_q && rd_occ && ((33'(sqx) + 33'(sqy)) < 33'(radius_sq[32:0]))
                && (radius_sq[34:33] == 2'b00) || (eval_q && rd_occ && radius_sq[34:33] != 2'b00);

  always_comb begin
    st           = '0;
    st.div_done  = dvx_seen && dvy_seen;
    st.clr_last  = (clr_addr == '1);
    st.ep_full   = (epoch == '1);
    st.is_clear  = (op == pdcf_pkg::OP_CLEAR);
    st.is_force  = (op == pdcf_pkg::OP_FORCE);
    st.is_test   = (op == pdcf_pkg::OP_TEST);
    st.pre_ok    = (px < area_width) && (py < area_height) && !own_occ;
    st.scan_last = col_end && row_end;
    st.near_hit  = near;
  end

  assign res_col = (st.is_test || st.is_force) ? 6'(col) : 6'd0;
  assign res_row = (st.is_test || st.is_force) ? 6'(row) : 6'd0;
endmodule

[sv/poisson_disc_candidate_filter_top.sv]
// channel   | dir | tdata / tuser fields (lowest bit first)
// s_axis    | in  | tdata: op[1:0], point_x[17:2], point_y[33:18]
// m_axis    | out | tdata: accepted[0], cell_col[6:1], cell_row[12:7]
// cfg       | in  | cfg_we, cfg_index, cfg_data (35 bits)
// one item at a time; a test item is taken in and decoded, runs the two bit-serial dividers, then
// reads, waits on and evaluates each scanned cell for up to 25 cells, stores if accepted and sends out
// a force insert skips the scan, and so does a test rejected outside the area or on a taken cell
// clear grid moves to a new epoch; every 15th clear instead runs a tag pass over the whole tag memory
// reset is synchronous and runs the same tag pass before tready rises
// the output register lets the next item enter while a result waits; a full one holds the out state
module poisson_disc_candidate_filter_top #(
  parameter int MAX_GRID_COLS = pdcf_pkg::MAX_GRID_COLS_DEF,
  parameter int MAX_GRID_ROWS = pdcf_pkg::MAX_GRID_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // op, point_x, point_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // accepted, cell_col, cell_row
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [34:0] cfg_data
);
  pdcf_pkg::cmd_t  cmd;
  pdcf_pkg::stat_t st;

  logic [15:0] area_width, area_height, cell_edge;
  logic [34:0] radius_sq;
  logic [6:0]  grid_cols, grid_rows;
  logic [5:0]  res_col, res_row;
  logic        in_fire;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      area_width  <= 16'd16384;
      area_height <= 16'd16384;
      cell_edge   <= 16'd256;
      radius_sq   <= 35'd131072;
      grid_cols   <= 7'd64;
      grid_rows   <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        pdcf_pkg::CFG_AREA_WIDTH:  area_width  <= cfg_data[15:0];
        pdcf_pkg::CFG_AREA_HEIGHT: area_height <= cfg_data[15:0];
        pdcf_pkg::CFG_CELL_EDGE:   cell_edge   <= cfg_data[15:0];
        pdcf_pkg::CFG_RADIUS_SQ:   radius_sq   <= cfg_data;
        pdcf_pkg::CFG_GRID_COLS:   grid_cols   <= cfg_data[6:0];
        pdcf_pkg::CFG_GRID_ROWS:   grid_rows   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign in_fire = s_axis_tvalid && s_axis_tready;

  pdcf_ctrl u_ctrl (
    .clk, .rst, .in_fire,
    .out_busy(m_axis_tvalid && !m_axis_tready),
    .st, .in_ready(s_axis_tready), .cmd
  );

  pdcf_dp #(.MAX_GRID_COLS(MAX_GRID_COLS), .MAX_GRID_ROWS(MAX_GRID_ROWS)) u_dp (
    .clk, .rst, .cmd,
    .in_op(s_axis_tdata[1:0]), .in_x(s_axis_tdata[17:2]), .in_y(s_axis_tdata[33:18]),
    .area_width, .area_height, .cell_edge, .radius_sq, .grid_cols, .grid_rows,
    .st, .res_col, .res_row
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (cmd.out_load) m_axis_tvalid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) m_axis_tdata <= {3'b0, res_row, res_col, cmd.set_acc};
  end
endmodule

[sv/pdcf_checker.sv]
`include "poisson_disc_candidate_filter_top_macros.svh"

module pdcf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);
  `PDCF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid,
    "result dropped while stalled")
  `PDCF_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready,
    "second item taken while busy")
  `PDCF_ASSERT_IMPL(a_pad_zero, m_axis_tvalid, m_axis_tdata[15:13] == 3'b000,
    "padding bits set")
  `PDCF_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata),
    "result changed while stalled")
endmodule

bind poisson_disc_candidate_filter_top pdcf_checker u_pdcf_checker (
  .clk, .rst, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata
);

[tb/sv/poisson_disc_candidate_filter_top_tb.sv]
`timescale 1ns / 1ps

module poisson_disc_candidate_filter_top_tb;

  // op value three is not named by the package: the block answers it with an all-zero result
  localparam logic [1:0] OP_NOP = 2'd3;
  // register indexes with no register behind them
  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;
  // cycles for the block to go quiet after its last result
  localparam int SETTLE_CYCLES = 160;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 115;

  typedef struct packed {
    logic [5:0] cell_row;
    logic [5:0] cell_col;
    logic       accepted;
  } cell_result_t;

  // grid predictor and queue of expected results
  class disc_grid_model;
    logic [15:0] area_w, area_h, cell_sz;
    logic [34:0] min_dist_sq;
    logic [6:0]  cols_reg, rows_reg;
    bit          occupied[4096];
    logic [15:0] stored_x[4096];
    logic [15:0] stored_y[4096];
    cell_result_t expected_cells[$];
    int mismatches, results_seen, accepts, rejects;

    function new();
      area_w = 16'd16384;
      area_h = 16'd16384;
      cell_sz = 16'd256;
      min_dist_sq = 35'd131072;
      cols_reg = 7'd64;
      rows_reg = 7'd64;
      foreach (occupied[i]) occupied[i] = 1'b0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [34:0] val);
      case (idx)
        pdcf_pkg::CFG_AREA_WIDTH:  area_w = val[15:0];
        pdcf_pkg::CFG_AREA_HEIGHT: area_h = val[15:0];
        pdcf_pkg::CFG_CELL_EDGE:   cell_sz = val[15:0];
        pdcf_pkg::CFG_RADIUS_SQ:   min_dist_sq = val;
        pdcf_pkg::CFG_GRID_COLS:   cols_reg = val[6:0];
        pdcf_pkg::CFG_GRID_ROWS:   rows_reg = val[6:0];
        default: ;
      endcase
    endfunction

    function int unsigned clamp_dim(logic [6:0] v);
      if (v == 0) return 1;
      if (v > 64) return 64;
      return v;
    endfunction

    function int unsigned cell_of(logic [15:0] coord, int unsigned lim);
      int unsigned q;
      q = (cell_sz == 0) ? 32'hFFFF_FFFF : coord / cell_sz;
      return (q > lim - 1) ? lim - 1 : q;
    endfunction

    // true when no stored point in the 5x5 window is too close
    function bit window_clear(int unsigned c, int unsigned r, int unsigned nc,
                              int unsigned nr, logic [15:0] x, logic [15:0] y);
      int unsigned c0, c1, r0, r1, k;
      longint dx, dy;
      longint unsigned d2;
      c0 = (c >= 2) ? c - 2 : 0;
      r0 = (r >= 2) ? r - 2 : 0;
      c1 = (c + 3 < nc) ? c + 3 : nc;
      r1 = (r + 3 < nr) ? r + 3 : nr;
      for (int unsigned rr = r0; rr < r1; rr++)
        for (int unsigned cc = c0; cc < c1; cc++) begin
          k = rr * 64 + cc;
          if (!occupied[k]) continue;
          dx = longint'(stored_x[k]) - longint'(x);
          dy = longint'(stored_y[k]) - longint'(y);
          d2 = dx * dx + dy * dy;
          if (d2 < min_dist_sq) return 1'b0;
        end
      return 1'b1;
    endfunction

    function void note_item(logic [1:0] op, logic [15:0] x, logic [15:0] y);
      cell_result_t res;
      int unsigned nc, nr, c, r, k;
      res = '0;
      if (op == pdcf_pkg::OP_CLEAR) begin
        foreach (occupied[i]) occupied[i] = 1'b0;
      end else if (op != OP_NOP) begin
        nc = clamp_dim(cols_reg);
        nr = clamp_dim(rows_reg);
        c = cell_of(x, nc);
        r = cell_of(y, nr);
        k = r * 64 + c;
        if (op == pdcf_pkg::OP_FORCE)
          res.accepted = 1'b1;
        else
          res.accepted = x < area_w && y < area_h && !occupied[k] &&
                         window_clear(c, r, nc, nr, x, y);
        if (res.accepted) begin
          occupied[k] = 1'b1;
          stored_x[k] = x;
          stored_y[k] = y;
        end
        res.cell_col = c[5:0];
        res.cell_row = r[5:0];
        if (op == pdcf_pkg::OP_TEST) begin
          if (res.accepted) accepts++;
          else rejects++;
        end
      end
      expected_cells.insert(expected_cells.size(), res);
    endfunction

    function void check_result(logic [15:0] data);
      cell_result_t got, exp_res;
      got = data[12:0];
      results_seen++;
      if (expected_cells.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", data);
        return;
      end
      exp_res = expected_cells.pop_front();
      if (got.accepted !== exp_res.accepted || got.cell_col !== exp_res.cell_col ||
          got.cell_row !== exp_res.cell_row || data[15:13] !== 3'b0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: expected acc %0d col %0d row %0d, got acc %0d col %0d row %0d",
                   results_seen, exp_res.accepted, exp_res.cell_col, exp_res.cell_row,
                   got.accepted, got.cell_col, got.cell_row);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // op, point_x, point_y
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // accepted, cell_col, cell_row
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [34:0] cfg_data;

  disc_grid_model grid_model;
  int burst_left;
  int items_sent;
  int stall_mode;

  poisson_disc_candidate_filter_top u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard limit well above the slowest legal run
  initial begin
    #40ms;
    $display("[poisson_disc_candidate_filter_top] ERROR");
    $finish;
  end

  // result side: check on the rising edge
  always @(posedge clk)
    if (!rst && m_axis_tvalid && m_axis_tready) grid_model.check_result(m_axis_tdata);

  // receiver stall pattern: one of four modes, picked anew at random from time to time
  int stall_cnt = 0;
  always @(negedge clk) begin
    if (stall_cnt % 64 == 0) stall_mode = $urandom_range(0, 3);
    stall_cnt++;
    case (stall_mode)
      0: m_axis_tready <= 1'b1;                               // no stalls
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= ($urandom_range(0, 7) == 0);        // long stalls
      default: m_axis_tready <= ((stall_cnt / 5) % 2 == 0);   // square wave
    endcase
  end

  task automatic send_item(logic [1:0] op, logic [15:0] x, logic [15:0] y);
    int gap;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, y, x, op};
    do @(posedge clk); while (!s_axis_tready);
    grid_model.note_item(op, x, y);
    items_sent++;
    // bursts of random length, then a random gap
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // hold the sender until every result is back and the block is quiet
  task automatic drain;
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (grid_model.expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [34:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    grid_model.write_reg(idx, val);
  endtask

  task automatic random_config(int p);
    logic [15:0] cs;
    logic [6:0] nc, nr;
    case (p % 4)
      0: cs = 16'd0;
      1: cs = 16'd1;
      2: cs = 16'hFFFF;
      default: cs = 16'($urandom_range(16, 1024));
    endcase
    if (p >= 4) cs = 16'($urandom_range(8, 600));
    nc = (p == 1) ? 7'd0 : (p == 2) ? 7'd127 : (p == 3) ? 7'd1 : 7'($urandom_range(1, 64));
    nr = (p == 1) ? 7'd127 : (p == 2) ? 7'd0 : (p == 3) ? 7'd64 : 7'($urandom_range(1, 64));
    write_reg(pdcf_pkg::CFG_CELL_EDGE, 35'(cs));
    write_reg(pdcf_pkg::CFG_GRID_COLS, 35'(nc));
    write_reg(pdcf_pkg::CFG_GRID_ROWS, 35'(nr));
    write_reg(pdcf_pkg::CFG_AREA_WIDTH,
              (p == 0) ? 35'd1 : (p == 5) ? 35'hFFFF : 35'($urandom_range(1, 65535)));
    write_reg(pdcf_pkg::CFG_AREA_HEIGHT,
              (p == 6) ? 35'hFFFF : 35'($urandom_range(1, 65535)));
    case ($urandom_range(0, 4))
      0: write_reg(pdcf_pkg::CFG_RADIUS_SQ, 35'd0);
      1: write_reg(pdcf_pkg::CFG_RADIUS_SQ, {35{1'b1}});
      2: write_reg(pdcf_pkg::CFG_RADIUS_SQ, 35'({$urandom, $urandom}));
      default: write_reg(pdcf_pkg::CFG_RADIUS_SQ, 35'(2 * cs * cs));  // about cell diagonal
    endcase
  endtask

  function automatic logic [15:0] pick_coord(logic [15:0] area);
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(0, 65535));
      1: return area;                       // right on the area edge
      default: return 16'($urandom_range(0, area == 0 ? 0 : area - 1));
    endcase
  endfunction

  initial begin
    logic [1:0] op;
    int pick;
    grid_model = new();
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    stall_mode = 0;
    burst_left = 0;
    items_sent = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset settings, cell 256, squared radius 131072 (about 362 units)
    send_item(pdcf_pkg::OP_FORCE, 16'd1000, 16'd1000);      // seed
    send_item(pdcf_pkg::OP_TEST, 16'd1100, 16'd1000);       // too close
    send_item(pdcf_pkg::OP_TEST, 16'd1900, 16'd1000);       // far enough
    send_item(pdcf_pkg::OP_TEST, 16'd1010, 16'd900);        // own cell taken
    send_item(pdcf_pkg::OP_TEST, 16'd0, 16'd0);
    send_item(pdcf_pkg::OP_TEST, 16'd16384, 16'd10);        // outside area
    send_item(pdcf_pkg::OP_TEST, 16'hFFFF, 16'hFFFF);       // saturated index
    send_item(pdcf_pkg::OP_FORCE, 16'hFFFF, 16'hFFFF);
    send_item(pdcf_pkg::OP_FORCE, 16'd1050, 16'd1020);      // lands in the cell beside the seed
    send_item(OP_NOP, 16'hFFFF, 16'hFFFF);
    send_item(pdcf_pkg::OP_TEST, 16'd16383, 16'd16383);
    send_item(pdcf_pkg::OP_CLEAR, 16'd5, 16'd5);
    send_item(pdcf_pkg::OP_TEST, 16'd1100, 16'd1000);       // grid empty again
    drain();
    // grid shrunk after inserts: far cells kept but not scanned
    send_item(pdcf_pkg::OP_FORCE, 16'd2600, 16'd2600);
    drain();
    write_reg(pdcf_pkg::CFG_GRID_COLS, 35'd8);
    write_reg(pdcf_pkg::CFG_GRID_ROWS, 35'd8);
    send_item(pdcf_pkg::OP_TEST, 16'd2650, 16'd2600);
    send_item(pdcf_pkg::OP_TEST, 16'd1900, 16'd1900);
    drain();
    write_reg(pdcf_pkg::CFG_CELL_EDGE, 35'd0);              // zero cell size
    send_item(pdcf_pkg::OP_TEST, 16'd3, 16'd4);
    send_item(pdcf_pkg::OP_FORCE, 16'd0, 16'd0);
    drain();
    write_reg(CFG_SPARE_LO, 35'h1234);                      // index with no register
    write_reg(CFG_SPARE_HI, 35'h5678);

    // random phases, each with its own settings
    for (int p = 0; p < PHASES; p++) begin
      drain();
      random_config(p);
      if (p % 2 == 0) send_item(pdcf_pkg::OP_CLEAR, 16'($urandom), 16'($urandom));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(0, 99);
        op = pick < 72 ? pdcf_pkg::OP_TEST : pick < 88 ? pdcf_pkg::OP_FORCE :
             pick < 94 ? pdcf_pkg::OP_CLEAR : OP_NOP;
        if (pick >= 97)
          send_item(op, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        else
          send_item(op, pick_coord(grid_model.area_w), pick_coord(grid_model.area_h));
      end
    end

    drain();
    $display("ran %0d items over %0d setting phases: %0d tests stored, %0d rejected",
             items_sent, PHASES + 1, grid_model.accepts, grid_model.rejects);
    $display("%0d results checked, %0d mismatches",
             grid_model.results_seen, grid_model.mismatches);
    if (grid_model.mismatches == 0 && grid_model.expected_cells.size() == 0)
      $display("[poisson_disc_candidate_filter_top] OK");
    else
      $display("[poisson_disc_candidate_filter_top] ERROR");
    $finish;
  end

endmodule
